FILE: rtl/ldi_pkg.sv
// Shared types, widths and constants for the Lambert diffuse intensity pipeline.
`default_nettype none
package ldi_pkg;

    // Beat field widths
    localparam int COORD_W = 32;
    localparam int NRM_W   = 16;
    localparam int BRT_W   = 17;
    localparam int OUT_W   = 17;

    // Internal datapath widths
    localparam int DIFF_W  = COORD_W + 1;     // light minus point, magnitude
    localparam int POS_W   = $clog2(DIFF_W);  // leading-one position
    localparam int MAG_W   = 24;              // normalized component magnitude
    localparam int MAG_MSB = MAG_W - 1;       // target leading-one position
    localparam int SQ_W    = 2 * MAG_W;       // one squared component
    localparam int SUM_W   = SQ_W + 2;        // sum of three squares
    localparam int ROOT_W  = SUM_W / 2;       // floor square root
    localparam int PR_W    = NRM_W + MAG_W + 1; // normal times signed component
    localparam int DOT_W   = PR_W + 2;        // sum of three products
    localparam int ABS_W   = DOT_W - 1;       // magnitude of the dot product
    localparam int COS_SH  = 16;              // cosine scale before the divide
    localparam int NUM_W   = ABS_W + COS_SH;  // dividend width
    localparam int Q_W     = 33;              // cosine magnitude, Q2.30 plus guard
    localparam int PROD_W  = BRT_W + Q_W;     // brightness times cosine
    localparam int PROD_FRAC = 46;            // fraction bits of that product

    localparam int OUT_FRAC_DEF = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [NRM_W-1:0]   normal_x;
        logic signed [NRM_W-1:0]   normal_y;
        logic signed [NRM_W-1:0]   normal_z;
        logic signed [COORD_W-1:0] light_x;
        logic signed [COORD_W-1:0] light_y;
        logic signed [COORD_W-1:0] light_z;
        logic        [BRT_W-1:0]   brightness;
        logic                      two_sided;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] intensity;
        logic             degenerate;
    } t_out_beat;

endpackage
`default_nettype wire

FILE: rtl/ldi_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
`default_nettype none
module ldi_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  wire                          i_v,
    input  wire  [ldi_pkg::SUM_W-1:0]    i_rad,
    input  wire  [SIDE_W-1:0]            i_side,
    output logic                         o_v,
    output logic [ldi_pkg::ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]            o_side
);
    localparam int RW    = ldi_pkg::ROOT_W;
    localparam int SW    = ldi_pkg::SUM_W;
    localparam int REM_W = RW + 2;

    logic              r_v    [RW];
    logic [REM_W-1:0]  r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SW-1:0]     r_rad  [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        localparam int B = RW - 1 - k;
        logic              w_v_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [RW-1:0]     w_root_in;
        logic [SW-1:0]     w_rad_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;

        if (k == 0) begin : g_first
            assign w_v_in    = i_v;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_side_in = r_side[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1
        assign w_cur   = {w_rem_in[REM_W-3:0], w_rad_in[2*B+1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rad[k]  <= w_rad_in;
                r_side[k] <= w_side_in;
                if (w_cur >= w_trial) begin
                    r_rem[k]  <= w_cur - w_trial;
                    r_root[k] <= {w_root_in[RW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur;
                    r_root[k] <= {w_root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_v    = r_v[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];
endmodule
`default_nettype wire

FILE: rtl/ldi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module ldi_div #(
    parameter int SIDE_W = 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  wire                          i_v,
    input  wire  [ldi_pkg::NUM_W-1:0]    i_num,
    input  wire  [ldi_pkg::ROOT_W-1:0]   i_den,
    input  wire  [SIDE_W-1:0]            i_side,
    output logic                         o_v,
    output logic [ldi_pkg::Q_W-1:0]      o_quo,
    output logic [SIDE_W-1:0]            o_side
);
    localparam int QW    = ldi_pkg::Q_W;
    localparam int NW    = ldi_pkg::NUM_W;
    localparam int DW    = ldi_pkg::ROOT_W;
    localparam int CUR_W = DW + 1;

    logic              r_v    [QW];
    logic [DW-1:0]     r_rem  [QW];
    logic [QW-1:0]     r_quo  [QW];
    logic [NW-1:0]     r_num  [QW];
    logic [DW-1:0]     r_den  [QW];
    logic [SIDE_W-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        localparam int B = QW - 1 - k;
        logic              w_v_in;
        logic [DW-1:0]     w_rem_in;
        logic [QW-1:0]     w_quo_in;
        logic [NW-1:0]     w_num_in;
        logic [DW-1:0]     w_den_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [CUR_W-1:0]  w_cur;
        logic [CUR_W-1:0]  w_diff;

        if (k == 0) begin : g_first
            // Quotient fits QW bits, so the top dividend bits are below the divisor
            assign w_v_in    = i_v;
            assign w_rem_in  = i_num[NW-1:QW];
            assign w_quo_in  = '0;
            assign w_num_in  = i_num;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_num_in  = r_num[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
        end

        // Shift in the next dividend bit and subtract if it fits
        assign w_cur  = {w_rem_in, w_num_in[B]};
        assign w_diff = w_cur - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[k]  <= w_num_in;
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
                if (w_cur >= {1'b0, w_den_in}) begin
                    r_rem[k] <= w_diff[DW-1:0];
                    r_quo[k] <= {w_quo_in[QW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_cur[DW-1:0];
                    r_quo[k] <= {w_quo_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_v    = r_v[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];
endmodule
`default_nettype wire

FILE: rtl/lambert_diffuse_intensity.sv
// Lambert diffuse intensity: fully pipelined shading of one sample per beat.
// Takes one input beat per clock when not stalled, returns one result beat per
// input beat, in order. Six front stages (difference and magnitude, maximum,
// leading-one search, normalizing shift, products, sums) and a stage that
// folds or clamps a negative dot product are followed by a 25-stage square
// root, a 33-stage divider (one bit per stage), the brightness multiply and
// the rounding/output register. A downstream stall freezes the whole
// pipeline; o_stall follows it only while the output register holds an
// untaken beat. When the point equals the light position the result is
// intensity 0 with degenerate set.
`default_nettype none
module lambert_diffuse_intensity #(
    parameter int OUT_FRAC_BITS = ldi_pkg::OUT_FRAC_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire ldi_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  wire               i_stall,
    output ldi_pkg::t_out_beat o_data
);
    localparam int CW   = ldi_pkg::COORD_W;
    localparam int DW   = ldi_pkg::DIFF_W;
    localparam int PW   = ldi_pkg::POS_W;
    localparam int MW   = ldi_pkg::MAG_W;
    localparam int NW   = ldi_pkg::NRM_W;
    localparam int BW   = ldi_pkg::BRT_W;
    localparam int OW   = ldi_pkg::OUT_W;
    localparam int SH   = ldi_pkg::PROD_FRAC - OUT_FRAC_BITS;
    localparam int RND_W = ldi_pkg::PROD_W + 1;
    localparam logic [RND_W-1:0] HALF = RND_W'(1) << (SH - 1);
    localparam logic [RND_W-1:0] CAP  = RND_W'(1) << OUT_FRAC_BITS;
    localparam int SQ_SIDE_W  = ldi_pkg::ABS_W + BW + 1;
    localparam int DIV_SIDE_W = BW + 1;

    logic w_adv;

    // Advance everything unless a finished beat is held by the receiver
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // Stage 1: difference and magnitude
    logic          r1_v;
    logic [DW-1:0] r1_mag [3];
    logic          r1_neg [3];
    logic signed [NW-1:0] r1_nrm [3];
    logic [BW-1:0] r1_brt;
    logic          r1_two;
    logic signed [DW-1:0] w1_d [3];
    logic signed [CW-1:0] w1_pt [3];
    logic signed [CW-1:0] w1_lt [3];

    assign w1_pt[0] = i_data.point_x;
    assign w1_pt[1] = i_data.point_y;
    assign w1_pt[2] = i_data.point_z;
    assign w1_lt[0] = i_data.light_x;
    assign w1_lt[1] = i_data.light_y;
    assign w1_lt[2] = i_data.light_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w1_d[i] = DW'(w1_lt[i]) - DW'(w1_pt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= w1_d[i][DW-1];
                r1_mag[i] <= w1_d[i][DW-1] ? DW'(-w1_d[i]) : DW'(w1_d[i]);
            end
            r1_nrm[0] <= i_data.normal_x;
            r1_nrm[1] <= i_data.normal_y;
            r1_nrm[2] <= i_data.normal_z;
            r1_brt    <= i_data.brightness;
            r1_two    <= i_data.two_sided;
        end
    end

    // Stage 2: largest magnitude
    logic          r2_v;
    logic [DW-1:0] r2_mag [3];
    logic          r2_neg [3];
    logic signed [NW-1:0] r2_nrm [3];
    logic [BW-1:0] r2_brt;
    logic          r2_two;
    logic [DW-1:0] r2_m;
    logic [DW-1:0] w2_m01;

    assign w2_m01 = (r1_mag[1] > r1_mag[0]) ? r1_mag[1] : r1_mag[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
            r2_nrm <= r1_nrm;
            r2_brt <= r1_brt;
            r2_two <= r1_two;
            r2_m   <= (r1_mag[2] > w2_m01) ? r1_mag[2] : w2_m01;
        end
    end

    // Stage 3: leading-one position of the maximum
    logic          r3_v;
    logic [DW-1:0] r3_mag [3];
    logic          r3_neg [3];
    logic signed [NW-1:0] r3_nrm [3];
    logic [BW-1:0] r3_brt;
    logic          r3_two;
    logic [PW-1:0] r3_pos;
    logic          r3_zero;
    logic [PW-1:0] w3_pos;

    always_comb begin
        w3_pos = '0;
        for (int k = 0; k < DW; k++) begin
            if (r2_m[k]) begin
                w3_pos = PW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_nrm  <= r2_nrm;
            r3_brt  <= r2_brt;
            r3_two  <= r2_two;
            r3_pos  <= w3_pos;
            r3_zero <= (r2_m == '0);
        end
    end

    // Stage 4: common normalizing shift
    logic          r4_v;
    logic [MW-1:0] r4_mag [3];
    logic          r4_neg [3];
    logic signed [NW-1:0] r4_nrm [3];
    logic [BW-1:0] r4_brt;
    logic          r4_two;
    logic          r4_zero;
    logic [DW-1:0] w4_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r3_pos >= PW'(ldi_pkg::MAG_MSB)) begin
                w4_sh[i] = r3_mag[i] >> (r3_pos - PW'(ldi_pkg::MAG_MSB));
            end else begin
                w4_sh[i] = r3_mag[i] << (PW'(ldi_pkg::MAG_MSB) - r3_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= w4_sh[i][MW-1:0];
            end
            r4_neg  <= r3_neg;
            r4_nrm  <= r3_nrm;
            r4_brt  <= r3_brt;
            r4_two  <= r3_two;
            r4_zero <= r3_zero;
        end
    end

    // Stage 5: squares and normal products
    logic                 r5_v;
    logic [ldi_pkg::SQ_W-1:0]        r5_sq [3];
    logic signed [ldi_pkg::PR_W-1:0] r5_pr [3];
    logic [BW-1:0]        r5_brt;
    logic                 r5_two;
    logic                 r5_zero;
    logic signed [MW:0]   w5_sd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w5_sd[i] = r4_neg[i] ? -$signed({1'b0, r4_mag[i]}) : $signed({1'b0, r4_mag[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= ldi_pkg::SQ_W'(r4_mag[i]) * ldi_pkg::SQ_W'(r4_mag[i]);
                r5_pr[i] <= ldi_pkg::PR_W'(r4_nrm[i]) * ldi_pkg::PR_W'(w5_sd[i]);
            end
            r5_brt  <= r4_brt;
            r5_two  <= r4_two;
            r5_zero <= r4_zero;
        end
    end

    // Stage 6: sums
    logic                              r6_v;
    logic [ldi_pkg::SUM_W-1:0]         r6_s;
    logic signed [ldi_pkg::DOT_W-1:0]  r6_dot;
    logic [BW-1:0]                     r6_brt;
    logic                              r6_two;
    logic                              r6_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_s   <= ldi_pkg::SUM_W'(r5_sq[0]) + ldi_pkg::SUM_W'(r5_sq[1])
                    + ldi_pkg::SUM_W'(r5_sq[2]);
            r6_dot <= ldi_pkg::DOT_W'(r5_pr[0]) + ldi_pkg::DOT_W'(r5_pr[1])
                    + ldi_pkg::DOT_W'(r5_pr[2]);
            r6_brt  <= r5_brt;
            r6_two  <= r5_two;
            r6_zero <= r5_zero;
        end
    end

    // Stage 7: fold or clamp the negative cosine
    logic                              r7_v;
    logic [ldi_pkg::SUM_W-1:0]         r7_s;
    logic [ldi_pkg::ABS_W-1:0]         r7_abs;
    logic [BW-1:0]                     r7_brt;
    logic                              r7_zero;
    logic signed [ldi_pkg::DOT_W-1:0]  w7_neg;

    assign w7_neg = -r6_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_adv) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_s    <= r6_s;
            r7_brt  <= r6_brt;
            r7_zero <= r6_zero;
            if (r6_dot[ldi_pkg::DOT_W-1]) begin
                r7_abs <= r6_two ? w7_neg[ldi_pkg::ABS_W-1:0] : '0;
            end else begin
                r7_abs <= r6_dot[ldi_pkg::ABS_W-1:0];
            end
        end
    end

    // Square root of the squared length
    logic                          w_sq_v;
    logic [ldi_pkg::ROOT_W-1:0]    w_root;
    logic [SQ_SIDE_W-1:0]          w_sq_side;

    ldi_sqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_v     (r7_v),
        .i_rad   (r7_s),
        .i_side  ({r7_abs, r7_brt, r7_zero}),
        .o_v     (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Cosine magnitude: |dot| scaled up, over the length
    logic                      w_dv_v;
    logic [ldi_pkg::Q_W-1:0]   w_quo;
    logic [DIV_SIDE_W-1:0]     w_dv_side;
    logic [ldi_pkg::ABS_W-1:0] w_sq_abs;

    assign w_sq_abs = w_sq_side[SQ_SIDE_W-1 -: ldi_pkg::ABS_W];

    ldi_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_v     (w_sq_v),
        .i_num   ({w_sq_abs, {ldi_pkg::COS_SH{1'b0}}}),
        .i_den   (w_root),
        .i_side  (w_sq_side[DIV_SIDE_W-1:0]),
        .o_v     (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // Stage 8: brightness scale
    logic                         r8_v;
    logic [ldi_pkg::PROD_W-1:0]   r8_prod;
    logic                         r8_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_adv) begin
            r8_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_prod <= ldi_pkg::PROD_W'(w_dv_side[DIV_SIDE_W-1:1])
                     * ldi_pkg::PROD_W'(w_quo);
            r8_zero <= w_dv_side[0];
        end
    end

    // Output register: round half up, cap at 1.0
    logic [RND_W-1:0] w9_rnd;
    logic [RND_W-1:0] w9_res;

    assign w9_rnd = (RND_W'(r8_prod) + HALF) >> SH;
    assign w9_res = (w9_rnd > CAP) ? CAP : w9_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_data.intensity  <= r8_zero ? '0 : w9_res[OW-1:0];
            o_data.degenerate <= r8_zero;
        end
    end
endmodule
`default_nettype wire
